// ===== src/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 matrix inverse core
// Default number format, the front stage count and the cofactor index tables.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // Default element format: Q16.16 in 32 bits.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Elements of one matrix and registered stages ahead of the divider lanes.
  localparam int NUM_ELEM     = 9;
  localparam int FRONT_STAGES = 5;

  // Cofactor i = m[A]*m[B] - m[C]*m[D], row-major element indices.
  localparam int CF_A [NUM_ELEM] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
  localparam int CF_B [NUM_ELEM] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
  localparam int CF_C [NUM_ELEM] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};
  localparam int CF_D [NUM_ELEM] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};

  // Cofactors of the first-row elements (entries 0, 3 and 6), used for the determinant.
  localparam int DET_CF [3] = '{0, 3, 6};

endpackage

// ===== src/matrix3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core: 3x3 matrix inverse by adjugate and determinant
// Exact cofactors and determinant, nine parallel divider lanes, rounding and
// saturation to the element format.
// ----------------------------------------------------------------------------
// The divider lanes retire one quotient bit per stage.
// Throughput: one matrix per cycle; bubbles in the pipeline are closed up
// while the output is stalled, so input stops only when every stage is full.
// Reset: rst_n is synchronous, active low, and clears all stage valid bits.
module matrix3_inverse_core #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
  parameter int TDW       = ((9 * WORD_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // m_row0_col0, m_row0_col1, ... m_row2_col2, each WORD_BITS, zero padded
  input  logic [TDW-1:0] in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  // inv_row0_col0, inv_row0_col1, ... inv_row2_col2, each WORD_BITS, zero padded
  output logic [TDW-1:0] out_tdata,
  // invertible, saturated
  output logic [1:0]     out_tuser
);

  localparam int W   = WORD_BITS;
  localparam int NE  = m3i_pkg::NUM_ELEM;
  localparam int FS  = m3i_pkg::FRONT_STAGES;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 2;
  localparam int NST = FS + W + 2;

  logic [NST-1:0]      vld_r;
  logic [NST-1:0]      vld_nxt;
  logic [NST-1:0]      en;
  logic [W:0]          zero_r;

  logic signed [W-1:0] m     [NE];
  logic [CW-1:0]       cmag  [NE];
  logic                cneg  [NE];
  logic [DW-1:0]       dmag;
  logic                dneg;
  logic                dzero;
  logic [W:0]          quo   [NE];
  logic                qneg  [NE];
  logic                qovf  [NE];
  logic signed [W-1:0] inv   [NE];
  logic                invertible;
  logic                saturated;
  logic [9*W-1:0]      res_flat;

  // Unpack the request.
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      m[i] = $signed(in_tdata[i*W +: W]);
    end
  end

  // A stage loads when it is empty or its successor moves on.
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    if (en[0]) begin
      vld_nxt[0] = in_tvalid;
    end else begin
      vld_nxt[0] = vld_r[0];
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Singular flag travels beside the divider lanes.
  always_ff @(posedge clk) begin
    if (en[FS]) begin
      zero_r[0] <= dzero;
    end
    for (int k = 1; k <= W; k++) begin
      if (en[FS + k]) begin
        zero_r[k] <= zero_r[k-1];
      end
    end
  end

  m3i_front #(
    .WORD_BITS (W),
    .CW        (CW),
    .DW        (DW)
  ) u_front (
    .clk   (clk),
    .en    (en[FS-1:0]),
    .m     (m),
    .cmag  (cmag),
    .cneg  (cneg),
    .dmag  (dmag),
    .dneg  (dneg),
    .dzero (dzero)
  );

  // Nine divider lanes, one per inverse element.
  for (genvar i = 0; i < NE; i++) begin : g_lane
    m3i_div_lane #(
      .WORD_BITS (W),
      .FRAC_BITS (FRAC_BITS),
      .CW        (CW),
      .DW        (DW)
    ) u_lane (
      .clk  (clk),
      .en   (en[FS + W : FS]),
      .nmag (cmag[i]),
      .nneg (cneg[i]),
      .dmag (dmag),
      .dneg (dneg),
      .quo  (quo[i]),
      .neg  (qneg[i]),
      .ovf  (qovf[i])
    );
  end

  m3i_merge #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .en         (en[NST-1]),
    .quo        (quo),
    .neg        (qneg),
    .ovf        (qovf),
    .zero       (zero_r[W]),
    .inv        (inv),
    .invertible (invertible),
    .saturated  (saturated)
  );

  // Pack the result.
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      res_flat[i*W +: W] = inv[i];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = TDW'(res_flat);
  assign out_tuser  = {saturated, invertible};

endmodule

// ===== src/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Five stages: products, cofactors, split determinant products, determinant
// sum, then magnitudes and signs for the divider lanes.
// ----------------------------------------------------------------------------
module m3i_front #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int CW        = 2 * WORD_BITS + 1,
  parameter int DW        = 3 * WORD_BITS + 2
) (
  input  logic                                   clk,
  input  logic [m3i_pkg::FRONT_STAGES-1:0]       en,
  input  logic signed [WORD_BITS-1:0]            m      [m3i_pkg::NUM_ELEM],
  output logic [CW-1:0]                          cmag   [m3i_pkg::NUM_ELEM],
  output logic                                   cneg   [m3i_pkg::NUM_ELEM],
  output logic [DW-1:0]                          dmag,
  output logic                                   dneg,
  output logic                                   dzero
);

  localparam int W  = WORD_BITS;
  localparam int NE = m3i_pkg::NUM_ELEM;

  logic signed [2*W-1:0] pa_r   [NE];
  logic signed [2*W-1:0] pb_r   [NE];
  logic signed [W-1:0]   m1_r   [3];
  logic signed [W-1:0]   m2_r   [3];
  logic signed [CW-1:0]  c2_r   [NE];
  logic signed [CW-1:0]  c3_r   [NE];
  logic signed [CW-1:0]  c4_r   [NE];
  logic signed [2*W:0]   plo_r  [3];
  logic signed [2*W:0]   phi_r  [3];
  logic signed [DW-1:0]  det_r;
  logic signed [DW-1:0]  hsum;
  logic signed [DW-1:0]  lsum;
  logic [CW-1:0]         cmag_r [NE];
  logic                  cneg_r [NE];
  logic [DW-1:0]         dmag_r;
  logic                  dneg_r;
  logic                  dzero_r;

  // Stage 1: the eighteen element products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NE; i++) begin
        pa_r[i] <= m[m3i_pkg::CF_A[i]] * m[m3i_pkg::CF_B[i]];
        pb_r[i] <= m[m3i_pkg::CF_C[i]] * m[m3i_pkg::CF_D[i]];
      end
      for (int j = 0; j < 3; j++) begin
        m1_r[j] <= m[j];
      end
    end
  end

  // Stage 2: cofactors as exact differences.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NE; i++) begin
        c2_r[i] <= CW'(pa_r[i]) - CW'(pb_r[i]);
      end
      m2_r <= m1_r;
    end
  end

  // Stage 3: first-row elements times the low and high halves of the cofactors.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= m2_r[j] * $signed({1'b0, c2_r[m3i_pkg::DET_CF[j]][W-1:0]});
        phi_r[j] <= m2_r[j] * $signed(c2_r[m3i_pkg::DET_CF[j]][CW-1:W]);
      end
      c3_r <= c2_r;
    end
  end

  // Stage 4: determinant from the partial products.
  always_comb begin
    hsum = DW'(phi_r[0]) + DW'(phi_r[1]) + DW'(phi_r[2]);
    lsum = DW'(plo_r[0]) + DW'(plo_r[1]) + DW'(plo_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      det_r <= (hsum <<< W) + lsum;
      c4_r  <= c3_r;
    end
  end

  // Stage 5: magnitudes and signs for the dividers.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NE; i++) begin
        cneg_r[i] <= c4_r[i][CW-1];
        cmag_r[i] <= c4_r[i][CW-1] ? CW'(-c4_r[i]) : CW'(c4_r[i]);
      end
      dneg_r  <= det_r[DW-1];
      dmag_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      dzero_r <= (det_r == '0);
    end
  end

  assign cmag  = cmag_r;
  assign cneg  = cneg_r;
  assign dmag  = dmag_r;
  assign dneg  = dneg_r;
  assign dzero = dzero_r;

endmodule

// ===== src/m3i_div_lane.sv =====
// ----------------------------------------------------------------------------
// m3i_div_lane: pipelined restoring divider for one inverse element
// Finds floor(2*N/D) with N = |cofactor| * 2^(2*FRAC_BITS), one quotient bit
// per stage, and flags a quotient that cannot fit the output.
// ----------------------------------------------------------------------------
module m3i_div_lane #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
  parameter int CW        = 2 * WORD_BITS + 1,
  parameter int DW        = 3 * WORD_BITS + 2
) (
  input  logic                 clk,
  input  logic [WORD_BITS:0]   en,
  input  logic [CW-1:0]        nmag,
  input  logic                 nneg,
  input  logic [DW-1:0]        dmag,
  input  logic                 dneg,
  output logic [WORD_BITS:0]   quo,
  output logic                 neg,
  output logic                 ovf
);

  localparam int W   = WORD_BITS;
  localparam int RWA = DW + W + 1;
  localparam int RWB = CW + 2 * FRAC_BITS + 1;
  localparam int RW  = (RWA > RWB) ? RWA : RWB;
  localparam int NS  = W + 1;

  logic [RW-1:0] rem_r [NS-1];
  logic [DW-1:0] den_r [NS-1];
  logic [W:0]    quo_r [NS];
  logic          neg_r [NS];
  logic          ovf_r [NS];
  logic [RW-1:0] rem0;

  // Twice the scaled numerator enters the first stage.
  assign rem0 = RW'(nmag) << (2 * FRAC_BITS + 1);

  // Stage 0 also checks that the quotient fits in W+1 bits.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      if (rem0 >= (RW'(dmag) << W)) begin
        rem_r[0] <= rem0 - (RW'(dmag) << W);
        quo_r[0] <= (W+1)'(1) << W;
      end else begin
        rem_r[0] <= rem0;
        quo_r[0] <= '0;
      end
      den_r[0] <= dmag;
      neg_r[0] <= nneg ^ dneg;
      ovf_r[0] <= (rem0 >= (RW'(dmag) << (W + 1)));
    end
  end

  // One compare and subtract per stage for the remaining quotient bits.
  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [RW-1:0] sub;
    assign sub = RW'(den_r[k-1]) << (W - k);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (rem_r[k-1] >= sub) begin
          quo_r[k] <= quo_r[k-1] | ((W+1)'(1) << (W - k));
        end else begin
          quo_r[k] <= quo_r[k-1];
        end
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    // The last stage has no successor, so only earlier stages keep a remainder.
    if (k < NS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[k]) begin
          if (rem_r[k-1] >= sub) begin
            rem_r[k] <= rem_r[k-1] - sub;
          end else begin
            rem_r[k] <= rem_r[k-1];
          end
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = quo_r[NS-1];
  assign neg = neg_r[NS-1];
  assign ovf = ovf_r[NS-1];

endmodule

// ===== src/m3i_merge.sv =====
// ----------------------------------------------------------------------------
// m3i_merge: rounding, saturation and result register
// Rounds the nine lane quotients, clips them, merges the saturation flags
// and substitutes the identity for a singular matrix.
// ----------------------------------------------------------------------------
module m3i_merge #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [WORD_BITS:0]          quo  [m3i_pkg::NUM_ELEM],
  input  logic                        neg  [m3i_pkg::NUM_ELEM],
  input  logic                        ovf  [m3i_pkg::NUM_ELEM],
  input  logic                        zero,
  output logic signed [WORD_BITS-1:0] inv  [m3i_pkg::NUM_ELEM],
  output logic                        invertible,
  output logic                        saturated
);

  localparam int W  = WORD_BITS;
  localparam int NE = m3i_pkg::NUM_ELEM;
  localparam logic       ONE_SAT = (FRAC_BITS >= W - 1);
  localparam logic [W-1:0] ONE_VAL = ONE_SAT ? {1'b0, {(W-1){1'b1}}} : (W'(1) << FRAC_BITS);
  localparam logic [W:0] LIM_POS = ((W+1)'(1) << (W - 1)) - (W+1)'(1);
  localparam logic [W:0] LIM_NEG = (W+1)'(1) << (W - 1);

  logic [W+1:0]          rnd    [NE];
  logic [W:0]            mag    [NE];
  logic [W:0]            lim    [NE];
  logic [W:0]            val    [NE];
  logic                  clip   [NE];
  logic signed [W-1:0]   elem   [NE];
  logic                  any_clip;

  logic signed [W-1:0]   inv_r  [NE];
  logic                  ok_r;
  logic                  sat_r;

  // Round half away from zero, then clip each lane to its signed limit.
  always_comb begin
    any_clip = 1'b0;
    for (int i = 0; i < NE; i++) begin
      rnd[i]  = {1'b0, quo[i]} + (W+2)'(1);
      mag[i]  = rnd[i][W+1:1];
      lim[i]  = neg[i] ? LIM_NEG : LIM_POS;
      clip[i] = ovf[i] || (mag[i] > lim[i]);
      val[i]  = clip[i] ? lim[i] : mag[i];
      elem[i] = neg[i] ? W'(-val[i]) : W'(val[i]);
      any_clip = any_clip | clip[i];
    end
  end

  // Result register; a singular matrix yields the identity.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NE; i++) begin
        if (zero) begin
          inv_r[i] <= (i % 4 == 0) ? ONE_VAL : '0;
        end else begin
          inv_r[i] <= elem[i];
        end
      end
      ok_r  <= !zero;
      sat_r <= zero ? ONE_SAT : any_clip;
    end
  end

  assign inv        = inv_r;
  assign invertible = ok_r;
  assign saturated  = sat_r;

endmodule

// ===== src/m3i_checker.sv =====
// ----------------------------------------------------------------------------
// m3i_checker: port-level checks for the matrix inverse core
// Reset, stall and singular-result properties, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker #(
  parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
  parameter int TDW       = ((9 * WORD_BITS + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_tready,
  input logic           out_tvalid,
  input logic           out_tready,
  input logic [TDW-1:0] out_tdata,
  input logic [1:0]     out_tuser
);

  localparam int W = WORD_BITS;

  // No result right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Requests are refused only when the pipeline is full behind a stalled result.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with room in the pipeline");

  // A singular matrix returns the identity; the off-diagonal terms 1 and 3 must be zero.
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[2*W-1:W] == '0 && out_tdata[4*W-1:3*W] == '0)
    else $error("singular result is not the identity");

endmodule

bind matrix3_inverse_core m3i_checker #(.WORD_BITS(WORD_BITS), .TDW(TDW)) u_m3i_checker (.*);
